// ----- hw/rtl/ffs_pkg.sv -----
package ffs_pkg;

    localparam int FFS_MAX_LENGTH = 4096;
    localparam int FFS_HDR_DEPTH  = 18;
    localparam int FFS_DOC0_LEN   = 14;
    localparam int FFS_DOC1_LEN   = 5;

    typedef enum logic [3:0] {
        FMT_UNKNOWN = 4'd0,
        FMT_PNG     = 4'd1,
        FMT_JPEG    = 4'd2,
        FMT_GIF     = 4'd3,
        FMT_BMP     = 4'd4,
        FMT_ICO     = 4'd5,
        FMT_WAV     = 4'd6,
        FMT_MP3     = 4'd7,
        FMT_MP4     = 4'd8,
        FMT_ZIP     = 4'd9,
        FMT_GZIP    = 4'd10,
        FMT_PDF     = 4'd11,
        FMT_ELF     = 4'd12,
        FMT_HTML    = 4'd13,
        FMT_TEXT    = 4'd14
    } t_format;

    // Expected lower-case characters of "<!doctype html".
    function automatic logic [7:0] doc0_char(input logic [3:0] p);
        logic [7:0] c;
        case (p)
            4'd0:    c = "<";
            4'd1:    c = "!";
            4'd2:    c = "d";
            4'd3:    c = "o";
            4'd4:    c = "c";
            4'd5:    c = "t";
            4'd6:    c = "y";
            4'd7:    c = "p";
            4'd8:    c = "e";
            4'd9:    c = " ";
            4'd10:   c = "h";
            4'd11:   c = "t";
            4'd12:   c = "m";
            4'd13:   c = "l";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected lower-case characters of "<html".
    function automatic logic [7:0] doc1_char(input logic [2:0] p);
        logic [7:0] c;
        case (p)
            3'd0:    c = "<";
            3'd1:    c = "h";
            3'd2:    c = "t";
            3'd3:    c = "m";
            3'd4:    c = "l";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/file_format_sniffer.sv -----
// File format sniffer.
// The slave stream carries a buffer one byte per transaction (tdata = the
// byte, tlast = final byte of the buffer). On the final byte the block issues
// one transaction on the master stream whose tdata[3:0] holds the format code;
// no other byte produces a result. All tracking state apart from the header
// store clears after each result, so the next buffer may follow immediately.
// Throughput is one byte per cycle, except that a final byte waits while a
// stalled result is held. A byte is captured in an input register, from which
// a single stage of logic updates the counters, header store and running
// checks; on the final byte the same stage loads the result register.
// When the receiver stalls, the held result blocks only a further final byte;
// ordinary bytes keep flowing into the tracking state meanwhile.
// Reset (synchronous, active low) empties both registers and restores the
// tracking state apart from the header store to its initial values. Byte and
// control counters saturate at MAX_LENGTH.
module file_format_sniffer
    import ffs_pkg::*;
#(
    parameter int MAX_LENGTH = FFS_MAX_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [3:0] format_code, [7:4] zero
);

    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LENGTH);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_last;
    logic            r_out_valid;
    t_format         r_out_code;

    logic [7:0]      r_hdr [FFS_HDR_DEPTH];
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_odd;
    logic            r_rejected;
    logic [1:0]      r_pending;
    logic            r_ws_phase;
    logic [3:0]      r_prog0;
    logic [2:0]      r_prog1;
    logic            r_miss0;
    logic            r_miss1;

    logic [7:0]      u_hdr [FFS_HDR_DEPTH];
    logic [CW-1:0]   u_count;
    logic [CW-1:0]   u_odd;
    logic            u_rejected;
    logic [1:0]      u_pending;
    logic            u_ws_phase;
    logic [3:0]      u_prog0;
    logic [2:0]      u_prog1;
    logic            u_miss0;
    logic            u_miss1;
    logic [7:0]      lc;
    t_format         n_code;

    logic            out_free;
    logic            advance;
    logic            finish;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!r_in_last || out_free);
    assign finish        = advance && r_in_last;
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_code};

    // Tracking state after the byte in the input register.
    always_comb begin
        for (int i = 0; i < FFS_HDR_DEPTH; i++) begin
            u_hdr[i] = (r_count == CW'(i)) ? r_in_byte : r_hdr[i];
        end
        u_count = (r_count < MAX_CNT) ? r_count + 1'b1 : r_count;

        u_odd      = r_odd;
        u_rejected = r_rejected;
        u_pending  = r_pending;
        if (!r_rejected) begin
            if (r_pending != 2'd0) begin
                if (r_in_byte[7:6] != 2'b10) u_rejected = 1'b1;
                else                         u_pending  = r_pending - 2'd1;
            end else if (r_in_byte == 8'h00) begin
                u_rejected = 1'b1;
            end else if (r_in_byte < 8'h80) begin
                if (r_in_byte < 8'd32 && !(r_in_byte inside {8'h09, 8'h0A, 8'h0D, 8'h0C})
                        && r_odd < MAX_CNT) begin
                    u_odd = r_odd + 1'b1;
                end
            end else if (r_in_byte inside {[8'hC2:8'hDF]}) begin
                u_pending = 2'd1;
            end else if (r_in_byte inside {[8'hE0:8'hEF]}) begin
                u_pending = 2'd2;
            end else if (r_in_byte inside {[8'hF0:8'hF4]}) begin
                u_pending = 2'd3;
            end else begin
                u_rejected = 1'b1;
            end
        end

        lc = (r_in_byte inside {["A":"Z"]}) ? (r_in_byte | 8'h20) : r_in_byte;
        u_ws_phase = r_ws_phase;
        u_prog0    = r_prog0;
        u_prog1    = r_prog1;
        u_miss0    = r_miss0;
        u_miss1    = r_miss1;
        if (!(r_ws_phase && (r_in_byte inside {8'h20, 8'h09, 8'h0D, 8'h0A}))) begin
            u_ws_phase = 1'b0;
            if (!r_miss0 && r_prog0 < 4'(FFS_DOC0_LEN)) begin
                if (lc == doc0_char(r_prog0)) u_prog0 = r_prog0 + 4'd1;
                else                          u_miss0 = 1'b1;
            end
            if (!r_miss1 && r_prog1 < 3'(FFS_DOC1_LEN)) begin
                if (lc == doc1_char(r_prog1)) u_prog1 = r_prog1 + 3'd1;
                else                          u_miss1 = 1'b1;
            end
        end
    end

    // Format decision, taken in priority order.
    always_comb begin
        n_code = FMT_UNKNOWN;
        if ({u_odd, 5'b00000} < {5'b00000, u_count} && !u_rejected) n_code = FMT_TEXT;
        if (!u_rejected && u_pending != 2'd0) n_code = FMT_TEXT;
        if (u_prog0 == 4'(FFS_DOC0_LEN) || u_prog1 == 3'(FFS_DOC1_LEN)) n_code = FMT_HTML;
        if (u_count >= CW'(3) && u_hdr[0] == 8'hFF && u_hdr[1][7:5] == 3'b111
                && u_hdr[1][4:3] != 2'd1 && u_hdr[1][2:1] != 2'd0
                && u_hdr[2][7:4] != 4'hF && u_hdr[2][3:2] != 2'd3) begin
            n_code = FMT_MP3;
        end
        // Signature table, lowest priority entry first so that later ones win.
        if (u_count >= CW'(8) && u_hdr[4] == "f" && u_hdr[5] == "t" && u_hdr[6] == "y"
                && u_hdr[7] == "p") n_code = FMT_MP4;
        if (u_count >= CW'(4) && u_hdr[0] == 8'h7F && u_hdr[1] == "E" && u_hdr[2] == "L"
                && u_hdr[3] == "F") n_code = FMT_ELF;
        if (u_count >= CW'(5) && u_hdr[0] == "%" && u_hdr[1] == "P" && u_hdr[2] == "D"
                && u_hdr[3] == "F" && u_hdr[4] == "-") n_code = FMT_PDF;
        if (u_count >= CW'(2) && u_hdr[0] == 8'h1F && u_hdr[1] == 8'h8B) n_code = FMT_GZIP;
        if (u_count >= CW'(4) && u_hdr[0] == "P" && u_hdr[1] == "K" && u_hdr[2] == 8'h03
                && u_hdr[3] == 8'h04) n_code = FMT_ZIP;
        if (u_count >= CW'(3) && u_hdr[0] == "I" && u_hdr[1] == "D" && u_hdr[2] == "3")
            n_code = FMT_MP3;
        if (u_count >= CW'(4) && u_hdr[0] == 8'h00 && u_hdr[1] == 8'h00
                && u_hdr[2] == 8'h01 && u_hdr[3] == 8'h00) n_code = FMT_ICO;
        if (u_count >= CW'(6) && u_hdr[0] == "G" && u_hdr[1] == "I" && u_hdr[2] == "F"
                && u_hdr[3] == "8" && (u_hdr[4] == "7" || u_hdr[4] == "9")
                && u_hdr[5] == "a") n_code = FMT_GIF;
        if (u_count >= CW'(3) && u_hdr[0] == 8'hFF && u_hdr[1] == 8'hD8 && u_hdr[2] == 8'hFF)
            n_code = FMT_JPEG;
        if (u_count >= CW'(8) && u_hdr[0] == 8'h89 && u_hdr[1] == "P" && u_hdr[2] == "N"
                && u_hdr[3] == "G" && u_hdr[4] == 8'h0D && u_hdr[5] == 8'h0A
                && u_hdr[6] == 8'h1A && u_hdr[7] == 8'h0A) n_code = FMT_PNG;
        if (u_count >= CW'(18) && u_hdr[0] == "B" && u_hdr[1] == "M"
                && u_hdr[6] == 8'h00 && u_hdr[7] == 8'h00 && u_hdr[8] == 8'h00
                && u_hdr[9] == 8'h00 && u_hdr[15] == 8'h00 && u_hdr[16] == 8'h00
                && u_hdr[17] == 8'h00
                && (u_hdr[14] inside {8'd12, 8'd40, 8'd52, 8'd56, 8'd64, 8'd108, 8'd124}))
            n_code = FMT_BMP;
        if (u_count >= CW'(12) && u_hdr[0] == "R" && u_hdr[1] == "I" && u_hdr[2] == "F"
                && u_hdr[3] == "F" && u_hdr[8] == "W" && u_hdr[9] == "A"
                && u_hdr[10] == "V" && u_hdr[11] == "E") n_code = FMT_WAV;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (finish) begin
            r_out_code <= n_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_hdr <= u_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_count    <= '0;
            r_odd      <= '0;
            r_rejected <= 1'b0;
            r_pending  <= 2'd0;
            r_ws_phase <= 1'b1;
            r_prog0    <= 4'd0;
            r_prog1    <= 3'd0;
            r_miss0    <= 1'b0;
            r_miss1    <= 1'b0;
        end else if (advance) begin
            r_count    <= u_count;
            r_odd      <= u_odd;
            r_rejected <= u_rejected;
            r_pending  <= u_pending;
            r_ws_phase <= u_ws_phase;
            r_prog0    <= u_prog0;
            r_prog1    <= u_prog1;
            r_miss0    <= u_miss0;
            r_miss1    <= u_miss1;
        end
    end

endmodule

// ----- hw/rtl/ffs_checker.sv -----
module ffs_checker
    import ffs_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The result register is empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // Only defined codes appear, with the upper bits clear.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'd0 && m_axis_tdata[3:0] <= FMT_TEXT))
        else $error("format code out of range");

    // A result that appears in an empty output register comes from a final byte
    // that passed straight from the input register into the result register; a final
    // byte held back by a stalled result never leaves the register empty.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("unexpected result");

endmodule

bind file_format_sniffer ffs_checker u_ffs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- test/file_format_sniffer_test.sv -----
`timescale 1ns / 100ps

module file_format_sniffer_test;
    import ffs_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [8*FFS_DOC0_LEN-1:0] DOCTYPE_OPEN = "<!doctype html";
    localparam logic [8*FFS_DOC1_LEN-1:0] HTML_OPEN    = "<html";

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;

    file_format_sniffer #(
        .MAX_LENGTH(FFS_MAX_LENGTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_tdata),    // [7:0] data_byte
        .s_axis_tlast (s_tlast),    // last_byte
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_axis_tdata) // [3:0] format_code, [7:4] zero
    );

    // Predicts the format code of each buffer and holds the codes still owed.
    class sniff_scoreboard;
        logic [7:0]  hdr [FFS_HDR_DEPTH];
        int unsigned nbytes;
        int unsigned nodd;
        bit          rejected;
        logic [1:0]  cont_left;
        bit          skipping_ws;
        int unsigned doc_pos [2];
        bit          doc_miss [2];
        t_format     expected_codes [$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            foreach (hdr[j]) hdr[j] = 8'h00;
            nbytes = 0;
            nodd = 0;
            rejected = 1'b0;
            cont_left = 2'd0;
            skipping_ws = 1'b1;
            doc_pos[0] = 0;
            doc_pos[1] = 0;
            doc_miss[0] = 1'b0;
            doc_miss[1] = 1'b0;
        endfunction

        function int pending();
            return expected_codes.size();
        endfunction

        // Pattern bytes are packed with the first byte in the most significant position.
        function bit match_at(int unsigned off, int unsigned len, logic [127:0] pat);
            if (nbytes < off + len) return 1'b0;
            for (int j = 0; j < len; j++) begin
                if (hdr[off + j] != pat[8*(len-1-j) +: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void track_text(logic [7:0] c);
            if (rejected) return;
            if (cont_left != 2'd0) begin
                if (c[7:6] != 2'b10) rejected = 1'b1;
                else cont_left = cont_left - 2'd1;
                return;
            end
            if (c == 8'h00) begin
                rejected = 1'b1;
            end else if (c < 8'h80) begin
                if (c < 8'h20 && c != 8'h09 && c != 8'h0A && c != 8'h0D && c != 8'h0C
                        && nodd < FFS_MAX_LENGTH)
                    nodd++;
            end else if (c >= 8'hC2 && c <= 8'hDF) begin
                cont_left = 2'd1;
            end else if (c >= 8'hE0 && c <= 8'hEF) begin
                cont_left = 2'd2;
            end else if (c >= 8'hF0 && c <= 8'hF4) begin
                cont_left = 2'd3;
            end else begin
                rejected = 1'b1;
            end
        endfunction

        function void track_html(logic [7:0] c);
            logic [7:0]  lc;
            logic [7:0]  want;
            int unsigned goal;
            if (skipping_ws) begin
                if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) return;
                skipping_ws = 1'b0;
            end
            lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
            for (int k = 0; k < 2; k++) begin
                goal = (k == 0) ? FFS_DOC0_LEN : FFS_DOC1_LEN;
                if (!doc_miss[k] && doc_pos[k] < goal) begin
                    want = (k == 0) ? DOCTYPE_OPEN[8*(goal-1-doc_pos[k]) +: 8]
                                    : HTML_OPEN[8*(goal-1-doc_pos[k]) +: 8];
                    if (lc == want) doc_pos[k]++;
                    else doc_miss[k] = 1'b1;
                end
            end
        endfunction

        function t_format classify();
            logic [31:0] dib;
            if (match_at(0, 4, "RIFF") && match_at(8, 4, "WAVE")) return FMT_WAV;
            if (nbytes >= FFS_HDR_DEPTH && match_at(0, 2, "BM") && match_at(6, 4, 0)) begin
                dib = {hdr[17], hdr[16], hdr[15], hdr[14]};
                case (dib)
                    32'd12, 32'd40, 32'd52, 32'd56, 32'd64, 32'd108, 32'd124: return FMT_BMP;
                    default: ;
                endcase
            end
            if (match_at(0, 8, 64'h89504E470D0A1A0A)) return FMT_PNG;
            if (match_at(0, 3, 24'hFFD8FF))           return FMT_JPEG;
            if (match_at(0, 6, "GIF87a"))             return FMT_GIF;
            if (match_at(0, 6, "GIF89a"))             return FMT_GIF;
            if (match_at(0, 4, 32'h00000100))         return FMT_ICO;
            if (match_at(0, 3, "ID3"))                return FMT_MP3;
            if (match_at(0, 4, 32'h504B0304))         return FMT_ZIP;
            if (match_at(0, 2, 16'h1F8B))             return FMT_GZIP;
            if (match_at(0, 5, "%PDF-"))              return FMT_PDF;
            if (match_at(0, 4, 32'h7F454C46))         return FMT_ELF;
            if (match_at(4, 4, "ftyp"))               return FMT_MP4;
            // Frame sync: version, layer, bitrate and sample rate must not be reserved.
            if (nbytes >= 3 && hdr[0] == 8'hFF && hdr[1][7:5] == 3'b111
                    && hdr[1][4:3] != 2'd1 && hdr[1][2:1] != 2'd0
                    && hdr[2][7:4] != 4'hF && hdr[2][3:2] != 2'd3)
                return FMT_MP3;
            if (doc_pos[0] == FFS_DOC0_LEN || doc_pos[1] == FFS_DOC1_LEN) return FMT_HTML;
            if (!rejected && nbytes != 0) begin
                if (cont_left != 2'd0) return FMT_TEXT;
                if (nodd * 32 < nbytes) return FMT_TEXT;
            end
            return FMT_UNKNOWN;
        endfunction

        function void note_byte(logic [7:0] c, bit last);
            if (nbytes < FFS_HDR_DEPTH) hdr[nbytes] = c;
            if (nbytes < FFS_MAX_LENGTH) nbytes++;
            track_text(c);
            track_html(c);
            if (last) begin
                expected_codes.push_back(classify());
                clear();
            end
        endfunction

        function void check_code(logic [7:0] got);
            t_format want;
            if (expected_codes.size() == 0) begin
                $display("%0t: unexpected format code, expected none, got %0d", $time, got);
                errors++;
                return;
            end
            want = expected_codes.pop_front();
            if (got !== {4'h0, want}) begin
                $display("%0t: format code mismatch, expected %0d, got %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    sniff_scoreboard sb = new();
    logic [7:0]      frame [$];
    int              rx_left = 0;
    int              idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        if (rx_left > 0) begin
            rx_left = rx_left - 1;
        end else if ($urandom_range(0, 1) == 0) begin
            m_tready <= 1'b0;
            rx_left = idle_len();
        end else begin
            m_tready <= 1'b1;
            rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_tready) sb.check_code(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] c, input bit last, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(c, last);
    endtask

    task automatic send_frame();
        bit burst;
        burst = ($urandom_range(0, 4) == 0);
        for (int j = 0; j < frame.size(); j++)
            push_byte(frame[j], j == frame.size() - 1, burst ? 0 : idle_len());
        frame.delete();
    endtask

    // Holds back further transactions until every owed code has arrived.
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic add_pattern(input logic [127:0] pat, input int len);
        for (int j = len - 1; j >= 0; j--) frame.push_back(pat[8*j +: 8]);
    endtask

    task automatic add_noise(input int n);
        repeat (n) frame.push_back(8'($urandom_range(0, 255)));
    endtask

    // Text-like bytes; a rough run also mixes in odd controls and illegal bytes.
    task automatic add_text(input int n, input bit rough);
        int r;
        int conts;
        repeat (n) begin
            r = $urandom_range(0, rough ? 99 : 87);
            if (r < 65) begin
                frame.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (r < 75) begin
                case ($urandom_range(0, 3))
                    0:       frame.push_back(8'h09);
                    1:       frame.push_back(8'h0A);
                    2:       frame.push_back(8'h0D);
                    default: frame.push_back(8'h0C);
                endcase
            end else if (r < 88) begin
                conts = $urandom_range(1, 3);
                case (conts)
                    1:       frame.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                    2:       frame.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                    default: frame.push_back(8'($urandom_range(8'hF0, 8'hF4)));
                endcase
                repeat (conts) frame.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else if (r < 95) begin
                frame.push_back($urandom_range(0, 1) ? 8'($urandom_range(1, 8))
                                                     : 8'($urandom_range(8'h0E, 8'h1F)));
            end else begin
                case ($urandom_range(0, 3))
                    0:       frame.push_back(8'h00);
                    1:       frame.push_back(8'($urandom_range(8'h80, 8'hC1)));
                    2:       frame.push_back(8'h0B);
                    default: frame.push_back(8'($urandom_range(8'hF5, 8'hFF)));
                endcase
            end
        end
    endtask

    task automatic add_opening();
        logic [127:0] pat;
        int           len;
        logic [7:0]   c;
        int           start;
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 8))
                0, 1:    frame.push_back(8'h20);
                2, 3:    frame.push_back(8'h09);
                4, 5:    frame.push_back(8'h0D);
                6, 7:    frame.push_back(8'h0A);
                default: frame.push_back(8'h0C);
            endcase
        end
        if ($urandom_range(0, 1)) begin
            pat = DOCTYPE_OPEN;
            len = FFS_DOC0_LEN;
        end else begin
            pat = HTML_OPEN;
            len = FFS_DOC1_LEN;
        end
        start = frame.size();
        for (int j = len - 1; j >= 0; j--) begin
            c = pat[8*j +: 8];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'h20;
            frame.push_back(c);
        end
        if ($urandom_range(0, 5) == 0)
            frame[start + $urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
        add_text($urandom_range(0, 20), $urandom_range(0, 1));
    endtask

    task automatic build_random_frame();
        int          kind;
        int          keep;
        logic [31:0] dib;
        kind = $urandom_range(0, 19);
        case (kind)
            0:  add_pattern(64'h89504E470D0A1A0A, 8);
            1:  add_pattern(24'hFFD8FF, 3);
            2:  add_pattern("GIF87a", 6);
            3:  add_pattern("GIF89a", 6);
            4:  add_pattern(32'h00000100, 4);
            5:  add_pattern("ID3", 3);
            6:  add_pattern(32'h504B0304, 4);
            7:  add_pattern(16'h1F8B, 2);
            8:  add_pattern("%PDF-", 5);
            9:  add_pattern(32'h7F454C46, 4);
            10: begin
                add_noise(4);
                add_pattern("ftyp", 4);
            end
            11: begin
                add_pattern("RIFF", 4);
                add_noise(4);
                add_pattern("WAVE", 4);
            end
            12: begin
                add_pattern("BM", 2);
                add_noise(4);
                if ($urandom_range(0, 5) == 0) add_noise(4);
                else add_pattern(0, 4);
                add_noise(4);
                case ($urandom_range(0, 9))
                    0:       dib = 32'd12;
                    1:       dib = 32'd40;
                    2:       dib = 32'd52;
                    3:       dib = 32'd56;
                    4:       dib = 32'd64;
                    5:       dib = 32'd108;
                    6:       dib = 32'd124;
                    7:       dib = $urandom_range(0, 130);
                    default: dib = $urandom;
                endcase
                for (int j = 0; j < 4; j++) frame.push_back(dib[8*j +: 8]);
            end
            13: begin
                frame.push_back(8'hFF);
                frame.push_back({3'b111, 5'($urandom_range(0, 31))});
                add_noise(1);
            end
            14, 15: add_opening();
            16, 17: begin
                add_text($urandom_range(1, 40), $urandom_range(0, 2) == 0);
                // Leave a multi-byte sequence cut off by the last byte now and then.
                if ($urandom_range(0, 3) == 0) begin
                    frame.push_back(8'($urandom_range(8'hC2, 8'hF4)));
                    if ($urandom_range(0, 1)) frame.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
            end
            default: add_noise($urandom_range(1, 40));
        endcase
        if (kind < 14) begin
            if ($urandom_range(0, 7) == 0) begin
                keep = $urandom_range(1, frame.size());
                while (frame.size() > keep) void'(frame.pop_back());
            end else begin
                if ($urandom_range(0, 7) == 0)
                    frame[$urandom_range(0, frame.size() - 1)] ^= 8'h01 << $urandom_range(0, 7);
                if ($urandom_range(0, 1)) add_noise($urandom_range(0, 20));
                else add_text($urandom_range(0, 20), $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        int random_bytes;
        bit paused_mid;
        random_bytes = 0;
        paused_mid = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Short directed buffers: a NUL byte, a lone letter, a cut-off UTF-8
        // sequence, gzip, JPEG, frame sync, a mixed-case HTML opening after
        // whitespace, a control-heavy pair and a single illegal byte.
        add_pattern(8'h00, 1);           send_frame();
        add_pattern("A", 1);             send_frame();
        add_pattern(16'hE282, 2);        send_frame();
        add_pattern(16'h1F8B, 2);        send_frame();
        add_pattern(24'hFFD8FF, 3);      send_frame();
        add_pattern(24'hFFFB90, 3);      send_frame();
        add_pattern({16'h200A, 40'h3C48744D6C}, 7); send_frame();
        add_pattern(16'h0141, 2);        send_frame();
        add_pattern(8'hFF, 1);           send_frame();
        drain();

        while (random_bytes < 925) begin
            build_random_frame();
            random_bytes += frame.size();
            send_frame();
            if (!paused_mid && random_bytes > 460) begin
                drain();
                paused_mid = 1'b1;
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
